### hw/rtl/rtpf_pkg.sv
// Shared types and constants for the H.264 RTP fragmenter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rtpf_pkg;

  localparam logic [4:0]  NAL_SEI   = 5'd6;
  localparam logic [4:0]  NAL_SPS   = 5'd7;
  localparam logic [4:0]  NAL_PPS   = 5'd8;
  localparam logic [7:0]  FU_A_TYPE = 8'd28;
  localparam logic [10:0] FRAG_MIN  = 11'd1024;
  localparam logic [10:0] FRAG_MAX  = 11'd1460;

  localparam logic [1:0] REG_TS_STEP   = 2'd0;
  localparam logic [1:0] REG_START_SEQ = 2'd1;
  localparam logic [1:0] REG_START_TS  = 2'd2;
  localparam logic [1:0] REG_FRAG_SIZE = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  // One classified NAL unit, as handed from the front to the back.
  typedef struct packed {
    logic [15:0] len;
    logic [4:0]  nal_type;
    logic        timed;
    logic        frag;
  } desc_t;

  // Counter load requests raised by configuration writes.
  typedef struct packed {
    logic        seq_load;
    logic [15:0] seq_value;
    logic        ts_load;
    logic [31:0] ts_value;
  } cnt_load_t;

  function automatic logic [10:0] clamp_fs(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v < FRAG_MIN) r = FRAG_MIN;
    if (v > FRAG_MAX) r = FRAG_MAX;
    return r;
  endfunction

endpackage

### hw/rtl/rtpf_front.sv
// Front end of the fragmenter: accepts NAL requests and classifies them.
// Depends on rtpf_pkg for the descriptor type and NAL type codes.
module rtpf_front #(
  parameter int MAX_NAL_BYTES = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               nal_valid,
  output logic               nal_ready,
  input  logic [7:0]         nal_header,
  input  logic [15:0]        nal_length,
  input  logic [10:0]        fs_eff,
  output logic               push,
  output rtpf_pkg::desc_t    push_data,
  input  logic               q_full
);

  logic            stg_valid;
  rtpf_pkg::desc_t stg;
  rtpf_pkg::desc_t cls;
  logic [15:0]     len_sat;
  logic [4:0]      ntype;
  logic            param_set;
  logic            take;

  assign take      = nal_valid && nal_ready;
  assign push      = stg_valid && !q_full;
  assign push_data = stg;
  assign nal_ready = !stg_valid || !q_full;

  always_comb begin
    ntype     = nal_header[4:0];
    len_sat   = (32'(nal_length) > 32'(MAX_NAL_BYTES)) ? 16'(MAX_NAL_BYTES) : nal_length;
    param_set = (ntype == rtpf_pkg::NAL_SPS) || (ntype == rtpf_pkg::NAL_PPS);
    cls.len      = len_sat;
    cls.nal_type = ntype;
    cls.timed    = !param_set && (ntype != rtpf_pkg::NAL_SEI);
    cls.frag     = !param_set && (len_sat > {5'b0, fs_eff});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg <= cls;
    end
  end

endmodule

### hw/rtl/rtpf_queue.sv
// Short descriptor queue between the front and back of the fragmenter.
// Depends on rtpf_pkg for the descriptor type and queue depth.
module rtpf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtpf_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output rtpf_pkg::desc_t q_data
);

  localparam int AW = (rtpf_pkg::QUEUE_DEPTH > 1) ? $clog2(rtpf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rtpf_pkg::QUEUE_DEPTH + 1);

  rtpf_pkg::desc_t mem [rtpf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(rtpf_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(rtpf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/rtpf_back.sv
// Back end of the fragmenter: walks one descriptor, one packet per cycle unless stalled.
// Holds the sequence and timestamp counters; depends on rtpf_pkg.
module rtpf_back #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rtpf_pkg::desc_t     q_data,
  output logic                q_pop,
  input  logic [31:0]         ts_step,
  input  logic [10:0]         fs_eff,
  input  rtpf_pkg::cnt_load_t cnt_load,
  output logic                pkt_valid,
  input  logic                pkt_ready,
  output logic                is_fragment,
  output logic [15:0]         sequence_number,
  output logic [31:0]         time_stamp,
  output logic [7:0]          frag_indicator,
  output logic [7:0]          frag_header,
  output logic [15:0]         payload_offset,
  output logic [15:0]         payload_length,
  output logic                last
);

  localparam int IW = (MAX_FRAGMENTS > 2) ? $clog2(MAX_FRAGMENTS) : 1;

  logic            active;
  rtpf_pkg::desc_t cur;
  logic [15:0]     rem;
  logic [15:0]     off;
  logic [IW-1:0]   idx;
  logic [15:0]     seq;
  logic [31:0]     ts;

  logic            adv;
  logic            last_c;
  logic [15:0]     plen;
  logic [15:0]     seq_next;
  logic [31:0]     ts_next;

  assign adv   = active && (!pkt_valid || pkt_ready);
  assign q_pop = !active && q_valid;

  always_comb begin
    // The fragment cap forces the last fragment to carry all remaining bytes.
    last_c   = !cur.frag || (rem <= {5'b0, fs_eff}) || (idx == IW'(MAX_FRAGMENTS - 1));
    plen     = last_c ? rem : {5'b0, fs_eff};
    seq_next = seq + 16'd1;
    ts_next  = cur.timed ? ts + ts_step : ts;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pkt_valid <= 1'b0;
      seq       <= 16'd0;
      ts        <= 32'd0;
    end else begin
      if (cnt_load.seq_load) begin
        seq <= cnt_load.seq_value;
      end else if (adv) begin
        seq <= seq_next;
      end
      if (cnt_load.ts_load) begin
        ts <= cnt_load.ts_value;
      end else if (adv) begin
        ts <= ts_next;
      end
      if (q_pop) begin
        active <= 1'b1;
      end else if (adv && last_c) begin
        active <= 1'b0;
      end
      if (adv) begin
        pkt_valid <= 1'b1;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      rem <= q_data.len;
      off <= 16'd0;
      idx <= '0;
    end else if (adv) begin
      rem <= rem - {5'b0, fs_eff};
      off <= off + {5'b0, fs_eff};
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_fragment     <= cur.frag;
      sequence_number <= seq_next;
      time_stamp      <= ts_next;
      frag_indicator  <= cur.frag ? rtpf_pkg::FU_A_TYPE : 8'd0;
      frag_header     <= cur.frag ? {idx == '0, last_c, 1'b0, cur.nal_type} : 8'd0;
      payload_offset  <= cur.frag ? off : 16'd0;
      payload_length  <= plen;
      last            <= last_c;
    end
  end

endmodule

### hw/rtl/h264_rtp_fragmenter.sv
// Top level of the H.264 RTP fragmenter: configuration registers and wiring.
// Depends on rtpf_pkg, rtpf_front, rtpf_queue and rtpf_back.
//
// Each request on the nal channel names one NAL unit by its header byte and
// length. The block answers with one packet descriptor per RTP packet on the
// pkt channel: a single NAL packet, or a run of FU-A fragments with start and
// end marks, each carrying its sequence number and timestamp.
// A request is classified in the front stage, waits in a two-entry queue, and
// is expanded by the back stage at one packet per cycle, while pkt_ready does
// not stall it, into an output register. The first packet passes the front
// staging register, the queue, the back stage's descriptor register and the
// output register in that order. The back stage pops the next descriptor only
// once it has produced the last packet of the current unit, so it sets the rate.
// The front keeps taking requests while the back works, until the queue fills.
// When the receiver drops pkt_ready the output register holds its packet and
// the back stage waits; requests back up into the queue and then nal_ready.
// Reset loads the register defaults (step 3000, fragment size 1400) and sets
// both counters to zero. Writing start_sequence or start_timestamp also loads
// the matching counter.
module h264_rtp_fragmenter #(
  parameter int MAX_NAL_BYTES = 65535,
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        nal_valid,
  output logic        nal_ready,
  input  logic [7:0]  nal_header,
  input  logic [15:0] nal_length,
  output logic        pkt_valid,
  input  logic        pkt_ready,
  output logic        is_fragment,
  output logic [15:0] sequence_number,
  output logic [31:0] time_stamp,
  output logic [7:0]  frag_indicator,
  output logic [7:0]  frag_header,
  output logic [15:0] payload_offset,
  output logic [15:0] payload_length,
  output logic        last
);

  logic [31:0] timestamp_step;
  logic [15:0] start_sequence;
  logic [31:0] start_timestamp;
  logic [10:0] fragment_size;
  logic [10:0] fs_eff;

  logic                wr_en;
  logic [1:0]          reg_idx;
  rtpf_pkg::cnt_load_t cnt_load;

  logic            push;
  rtpf_pkg::desc_t push_data;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  rtpf_pkg::desc_t q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cnt_load.seq_load  = wr_en && (reg_idx == rtpf_pkg::REG_START_SEQ);
    cnt_load.seq_value = pwdata[15:0];
    cnt_load.ts_load   = wr_en && (reg_idx == rtpf_pkg::REG_START_TS);
    cnt_load.ts_value  = pwdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_step  <= 32'd3000;
      start_sequence  <= 16'd0;
      start_timestamp <= 32'd0;
      fragment_size   <= 11'd1400;
      fs_eff          <= 11'd1400;
    end else if (wr_en) begin
      unique case (reg_idx)
        rtpf_pkg::REG_TS_STEP:   timestamp_step  <= pwdata;
        rtpf_pkg::REG_START_SEQ: start_sequence  <= pwdata[15:0];
        rtpf_pkg::REG_START_TS:  start_timestamp <= pwdata;
        rtpf_pkg::REG_FRAG_SIZE: begin
          fragment_size <= pwdata[10:0];
          fs_eff        <= rtpf_pkg::clamp_fs(pwdata[10:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rtpf_pkg::REG_TS_STEP:   prdata = timestamp_step;
      rtpf_pkg::REG_START_SEQ: prdata = {16'd0, start_sequence};
      rtpf_pkg::REG_START_TS:  prdata = start_timestamp;
      rtpf_pkg::REG_FRAG_SIZE: prdata = {21'd0, fragment_size};
      default:                 prdata = 32'd0;
    endcase
  end

  rtpf_front #(
    .MAX_NAL_BYTES(MAX_NAL_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .nal_valid  (nal_valid),
    .nal_ready  (nal_ready),
    .nal_header (nal_header),
    .nal_length (nal_length),
    .fs_eff     (fs_eff),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  rtpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rtpf_back #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .ts_step         (timestamp_step),
    .fs_eff          (fs_eff),
    .cnt_load        (cnt_load),
    .pkt_valid       (pkt_valid),
    .pkt_ready       (pkt_ready),
    .is_fragment     (is_fragment),
    .sequence_number (sequence_number),
    .time_stamp      (time_stamp),
    .frag_indicator  (frag_indicator),
    .frag_header     (frag_header),
    .payload_offset  (payload_offset),
    .payload_length  (payload_length),
    .last            (last)
  );

  // Every fragment but the last is exactly one fragment size long.
  a_frag_full_len: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && is_fragment && !last |-> payload_length == {5'b0, fs_eff})
    else $error("non-final fragment length differs from fragment size");

  // A single NAL packet always closes its unit.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !is_fragment |-> last)
    else $error("single NAL packet not marked last");

  // A taken middle fragment is followed at once by the next fragment of the run.
  a_frag_follow: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && is_fragment && !last |=>
      pkt_valid && is_fragment && !frag_header[7] &&
      sequence_number == $past(sequence_number) + 16'd1)
    else $error("fragment run broken");

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("descriptor queue overflow");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pkt_valid)
    else $error("packet valid after reset");

endmodule

### bench/tb_h264_rtp_fragmenter.sv
// Testbench for h264_rtp_fragmenter: sends NAL unit requests and APB register writes,
// predicts every packet descriptor and checks them in order against the pkt channel.
// Depends on rtpf_pkg and the fragmenter RTL.
module tb_h264_rtp_fragmenter;

  localparam int MAX_FRAGS    = 64;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CONFIG_EVERY = 36;

  typedef struct packed {
    logic        frag;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  ind;
    logic [7:0]  fuh;
    logic [15:0] off;
    logic [15:0] len;
    logic        last;
  } packet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        nal_valid = 1'b0;
  logic        nal_ready;
  logic [7:0]  nal_header = '0;
  logic [15:0] nal_length = '0;
  logic        pkt_valid;
  logic        pkt_ready = 1'b0;
  logic        is_fragment;
  logic [15:0] sequence_number;
  logic [31:0] time_stamp;
  logic [7:0]  frag_indicator;
  logic [7:0]  frag_header;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;
  logic        last;

  // Mirror of the block's registers and counters.
  logic [31:0] ts_step_q = 32'd3000;
  logic [10:0] frag_size_q = 11'd1400;
  logic [15:0] seq_cnt = '0;
  logic [31:0] ts_cnt = '0;

  packet_t expected_pkts[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  h264_rtp_fragmenter u_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) pkt_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic int eff_frag_size();
    if (frag_size_q < rtpf_pkg::FRAG_MIN) return int'(rtpf_pkg::FRAG_MIN);
    if (frag_size_q > rtpf_pkg::FRAG_MAX) return int'(rtpf_pkg::FRAG_MAX);
    return int'(frag_size_q);
  endfunction

  function automatic void add_packet(input logic frag, input logic [7:0] fuh,
                                     input logic [15:0] off, input logic [15:0] len,
                                     input logic last_pkt, input logic timed);
    packet_t p;
    seq_cnt = seq_cnt + 16'd1;
    if (timed) ts_cnt = ts_cnt + ts_step_q;
    p.frag = frag;
    p.seq  = seq_cnt;
    p.ts   = ts_cnt;
    p.ind  = frag ? rtpf_pkg::FU_A_TYPE : 8'd0;
    p.fuh  = fuh;
    p.off  = off;
    p.len  = len;
    p.last = last_pkt;
    expected_pkts.insert(expected_pkts.size(), p);
  endfunction

  function automatic void plan_packets(input logic [7:0] hdr, input logic [15:0] len);
    logic [4:0]  nal_type;
    logic        timed;
    logic        is_last;
    logic [15:0] off;
    int fs;
    int count;
    nal_type = hdr[4:0];
    fs = eff_frag_size();
    // Parameter sets always go out whole and never advance the timestamp.
    if (nal_type == rtpf_pkg::NAL_SPS || nal_type == rtpf_pkg::NAL_PPS) begin
      add_packet(1'b0, 8'd0, 16'd0, len, 1'b1, 1'b0);
      return;
    end
    timed = (nal_type != rtpf_pkg::NAL_SEI);
    if (int'(len) <= fs) begin
      add_packet(1'b0, 8'd0, 16'd0, len, 1'b1, timed);
      return;
    end
    count = (int'(len) + fs - 1) / fs;
    if (count > MAX_FRAGS) count = MAX_FRAGS;
    for (int i = 0; i < count; i++) begin
      is_last = (i == count - 1);
      off = 16'(i * fs);
      add_packet(1'b1, {(i == 0), is_last, 1'b0, nal_type}, off,
                 is_last ? len - off : 16'(fs), is_last, timed);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    packet_t want;
    if (!rst && pkt_valid && pkt_ready) begin
      if (expected_pkts.size() == 0) begin
        $error("packet seq 0x%0h arrived with no request pending", sequence_number);
        errors++;
      end else begin
        want = expected_pkts[0];
        expected_pkts.delete(0);
        check_field("is_fragment", want.frag, is_fragment);
        check_field("sequence_number", want.seq, sequence_number);
        check_field("time_stamp", want.ts, time_stamp);
        check_field("frag_indicator", want.ind, frag_indicator);
        check_field("frag_header", want.fuh, frag_header);
        check_field("payload_offset", want.off, payload_offset);
        check_field("payload_length", want.len, payload_length);
        check_field("last", want.last, last);
      end
    end
  end

  // Ends the run if neither channel nor the register port makes progress.
  always @(posedge clk) begin
    if ((nal_valid && nal_ready) || (pkt_valid && pkt_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_nal(input logic [7:0] hdr, input logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      nal_valid <= 1'b0;
      @(posedge clk);
    end
    nal_valid  <= 1'b1;
    nal_header <= hdr;
    nal_length <= len;
    do @(posedge clk); while (!nal_ready);
    plan_packets(hdr, len);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rtpf_pkg::REG_TS_STEP:   ts_step_q = value;
      rtpf_pkg::REG_START_SEQ: seq_cnt = value[15:0];
      rtpf_pkg::REG_START_TS:  ts_cnt = value;
      rtpf_pkg::REG_FRAG_SIZE: frag_size_q = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers may only change once every outstanding packet has drained.
  task automatic settle();
    nal_valid <= 1'b0;
    while (expected_pkts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_config();
    send_nal(8'h65, 16'd100);
    send_nal(8'h41, 16'd1400);
    send_nal(8'h41, 16'd1401);
    send_nal(8'h06, 16'd50);
    send_nal(8'h67, 16'd20);
    send_nal(8'h68, 16'd4);
    send_nal(8'h01, 16'd0);
    send_nal(8'hFF, 16'hFFFF);
  endtask

  task automatic test_counter_wrap();
    settle();
    apb_write(rtpf_pkg::REG_TS_STEP, 32'hFFFF_FFFF);
    apb_write(rtpf_pkg::REG_START_SEQ, 32'h0000_FFFE);
    apb_write(rtpf_pkg::REG_START_TS, 32'hFFFF_F000);
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'd1460);
    send_nal(8'h21, 16'd3000);
    send_nal(8'h66, 16'd5000);
    send_nal(8'h07, 16'hFFFF);
    send_nal(8'h7C, 16'd2);
  endtask

  task automatic test_fragment_size_limits();
    settle();
    apb_write(rtpf_pkg::REG_TS_STEP, 32'd0);
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'd0);
    send_nal(8'h05, 16'd1024);
    send_nal(8'h05, 16'd1025);
    // Smallest fragment size with the longest unit gives the most fragments.
    send_nal(8'h00, 16'hFFFF);
    settle();
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'd2047);
    send_nal(8'h85, 16'd1460);
    send_nal(8'h85, 16'd1461);
    send_nal(8'h9F, 16'hFFFF);
    settle();
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'd1023);
    send_nal(8'h45, 16'd1025);
    settle();
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'd1461);
    send_nal(8'h45, 16'd1461);
  endtask

  task automatic randomize_config();
    logic [31:0] step;
    logic [10:0] fs;
    case ($urandom_range(3))
      0: step = 32'd0;
      1: step = 32'hFFFF_FFFF;
      default: step = $urandom;
    endcase
    case ($urandom_range(9))
      0: fs = 11'($urandom_range(1023));
      1: fs = 11'($urandom_range(2047, 1461));
      default: fs = 11'($urandom_range(1460, 1024));
    endcase
    apb_write(rtpf_pkg::REG_TS_STEP, step);
    apb_write(rtpf_pkg::REG_START_SEQ, $urandom);
    apb_write(rtpf_pkg::REG_START_TS, $urandom);
    apb_write(rtpf_pkg::REG_FRAG_SIZE, 32'(fs));
  endtask

  task automatic send_random_nal();
    logic [7:0]  hdr;
    logic [15:0] len;
    int fs;
    int r;
    fs = eff_frag_size();
    hdr = 8'($urandom);
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(4))
        0: hdr[4:0] = rtpf_pkg::NAL_SEI;
        1: hdr[4:0] = rtpf_pkg::NAL_SPS;
        2: hdr[4:0] = rtpf_pkg::NAL_PPS;
        3: hdr[4:0] = 5'd5;
        default: hdr[4:0] = 5'd1;
      endcase
    end
    r = $urandom_range(99);
    if (r < 35)      len = 16'($urandom_range(fs, 1));
    else if (r < 75) len = 16'($urandom_range(8 * fs, fs + 1));
    else if (r < 88) len = 16'($urandom_range(65535, 8 * fs));
    else if (r < 91) len = 16'd0;
    else if (r < 94) len = 16'hFFFF;
    else             len = 16'(fs * $urandom_range(4, 1) + $urandom_range(1));
    send_nal(hdr, len);
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % CONFIG_EVERY == 0) begin
        settle();
        randomize_config();
      end
      send_random_nal();
    end
  endtask

  initial begin
    send_idle_pct = 20;
    recv_idle_pct = 62;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_config();
    test_counter_wrap();
    test_fragment_size_limits();
    test_random_traffic(107, 20, 62);
    test_random_traffic(107, 62, 20);
    test_random_traffic(106, 0, 0);
    settle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rtpf_pkg.sv
hw/rtl/rtpf_front.sv
hw/rtl/rtpf_queue.sv
hw/rtl/rtpf_back.sv
hw/rtl/h264_rtp_fragmenter.sv
bench/tb_h264_rtp_fragmenter.sv
